>>> rtl/core/ppid_pkg.sv
// Shared types, widths, register indexes and reset values for the PID controller.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ppid_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;               // measured sample and setpoint
    localparam int GAIN_W    = 16;               // Q8.8 gains
    localparam int FRAC_W    = 8;                // fraction bits of the gains
    localparam int ERR_W     = SAMPLE_W + 1;     // setpoint - measured
    localparam int DERIV_W   = ERR_W + 1;        // error - previous error
    localparam int INTEG_W   = 32;               // integral state and clamp limits
    localparam int SUM_W     = INTEG_W + 1;      // integral + error before clamping
    localparam int DRIVE_W   = 32;
    localparam int P_W       = GAIN_W + ERR_W;
    localparam int I_W       = GAIN_W + INTEG_W;
    localparam int D_W       = GAIN_W + DERIV_W;
    localparam int ACC_W     = I_W + 2;          // room for the three-term sum
    localparam int SHIFT_W   = ACC_W - FRAC_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 56;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INT_UP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LO   = 3'd5;

    // Reset values
    localparam logic signed [SAMPLE_W-1:0] SETPOINT_RST = 16'sd12;
    localparam logic signed [GAIN_W-1:0]   GAIN_P_RST   = 16'sd13312;
    localparam logic signed [GAIN_W-1:0]   GAIN_I_RST   = 16'sd512;
    localparam logic signed [GAIN_W-1:0]   GAIN_D_RST   = 16'sd0;
    localparam logic signed [INTEG_W-1:0]  INT_UP_RST   = 32'sh7FFF_FFFF;
    localparam logic signed [INTEG_W-1:0]  INT_LO_RST   = 32'sh8000_0000;

    localparam logic signed [DRIVE_W-1:0]  DRIVE_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [DRIVE_W-1:0]  DRIVE_MIN    = 32'sh8000_0000;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [GAIN_W-1:0]   gain_d;
        logic signed [INTEG_W-1:0]  int_upper;
        logic signed [INTEG_W-1:0]  int_lower;
    } cfg_t;

    // Error stage result
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
    } front_t;

    // Product stage result
    typedef struct packed {
        logic signed [P_W-1:0]   p_term;
        logic signed [I_W-1:0]   i_term;
        logic signed [D_W-1:0]   d_term;
        logic signed [ERR_W-1:0] err;
    } prod_t;

endpackage

`default_nettype wire

>>> rtl/core/ppid_front.sv
// Input register, error/integral/derivative stage and the controller state.
// Depends on ppid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppid_front import ppid_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cfg_t                       cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] in_meas,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output front_t                          out_res
);

    logic                       meas_vld_reg;
    logic signed [SAMPLE_W-1:0] meas_reg;
    logic                       res_vld_reg;
    front_t                     res_reg;
    logic signed [INTEG_W-1:0]  integral_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;

    logic                       out_advance;
    logic                       fire;
    logic signed [ERR_W-1:0]    err_c;
    logic signed [SUM_W-1:0]    sum_c;
    logic signed [SUM_W-1:0]    up_c;
    logic signed [SUM_W-1:0]    lo_c;
    logic signed [SUM_W-1:0]    hi_clip_c;
    logic signed [SUM_W-1:0]    clip_c;
    logic signed [DERIV_W-1:0]  deriv_c;
    front_t                     res_next;

    // Stage handshake
    assign out_advance = !res_vld_reg || out_ready;
    assign in_ready    = !meas_vld_reg || out_advance;
    assign fire        = meas_vld_reg && out_advance;

    // Error, clamped integral (upper first, lower last) and derivative
    always_comb begin
        err_c     = $signed({cfg.setpoint[SAMPLE_W-1], cfg.setpoint})
                  - $signed({meas_reg[SAMPLE_W-1], meas_reg});
        sum_c     = $signed({integral_reg[INTEG_W-1], integral_reg})
                  + $signed({{(SUM_W-ERR_W){err_c[ERR_W-1]}}, err_c});
        up_c      = $signed({cfg.int_upper[INTEG_W-1], cfg.int_upper});
        lo_c      = $signed({cfg.int_lower[INTEG_W-1], cfg.int_lower});
        hi_clip_c = (sum_c > up_c) ? up_c : sum_c;
        clip_c    = (hi_clip_c < lo_c) ? lo_c : hi_clip_c;
        deriv_c   = $signed({err_c[ERR_W-1], err_c})
                  - $signed({prev_err_reg[ERR_W-1], prev_err_reg});
        res_next.err   = err_c;
        res_next.integ = clip_c[INTEG_W-1:0];
        res_next.deriv = deriv_c;
    end

    // Valid flags and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meas_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            integral_reg <= '0;
            prev_err_reg <= '0;
        end else begin
            if (in_ready) begin
                meas_vld_reg <= in_valid;
            end
            if (out_advance) begin
                res_vld_reg <= meas_vld_reg;
            end
            if (fire) begin
                integral_reg <= res_next.integ;
                prev_err_reg <= res_next.err;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            meas_reg <= in_meas;
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_res   = res_reg;

    // Integral stays inside ordered limits after every update
    a_integ_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (cfg.int_lower <= cfg.int_upper)) |=>
        ((integral_reg <= $past(cfg.int_upper)) && (integral_reg >= $past(cfg.int_lower))))
        else $error("integral left the clamp window");

    // Crossed limits leave the integral at the lower limit
    a_integ_crossed: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (cfg.int_lower > cfg.int_upper)) |=>
        (integral_reg == $past(cfg.int_lower)))
        else $error("crossed limits did not resolve to lower limit");

    // Stored previous error matches the error handed downstream
    a_prev_err: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (prev_err_reg == res_reg.err))
        else $error("previous error out of step with stage output");

endmodule

`default_nettype wire

>>> rtl/core/ppid_mult.sv
// Product stage: the three gain multiplications, registered.
// Depends on ppid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppid_mult import ppid_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cfg_t   cfg,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire front_t in_res,
    output logic        out_valid,
    input  wire logic   out_ready,
    output prod_t       out_prod
);

    logic  prod_vld_reg;
    prod_t prod_reg;
    prod_t prod_next;

    assign in_ready = !prod_vld_reg || out_ready;

    // Signed gain products at full precision
    always_comb begin
        prod_next.p_term = $signed({{(P_W-GAIN_W){cfg.gain_p[GAIN_W-1]}}, cfg.gain_p})
                         * $signed({{(P_W-ERR_W){in_res.err[ERR_W-1]}}, in_res.err});
        prod_next.i_term = $signed({{(I_W-GAIN_W){cfg.gain_i[GAIN_W-1]}}, cfg.gain_i})
                         * $signed({{(I_W-INTEG_W){in_res.integ[INTEG_W-1]}}, in_res.integ});
        prod_next.d_term = $signed({{(D_W-GAIN_W){cfg.gain_d[GAIN_W-1]}}, cfg.gain_d})
                         * $signed({{(D_W-DERIV_W){in_res.deriv[DERIV_W-1]}}, in_res.deriv});
        prod_next.err    = in_res.err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else if (in_ready) begin
            prod_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = prod_vld_reg;
    assign out_prod  = prod_reg;

endmodule

`default_nettype wire

>>> rtl/core/ppid_out.sv
// Output stage: sum of terms, floor shift by the gain fraction, saturation,
// and the result register. Depends on ppid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppid_out import ppid_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire prod_t                  in_prod,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [DRIVE_W-1:0]   out_drive,
    output logic signed [ERR_W-1:0]     out_err
);

    logic                       out_vld_reg;
    logic signed [DRIVE_W-1:0]  drive_reg;
    logic signed [ERR_W-1:0]    err_reg;

    logic                       fire;
    logic signed [ACC_W-1:0]    acc_c;
    logic signed [SHIFT_W-1:0]  shifted_c;
    logic signed [DRIVE_W-1:0]  drive_next;

    assign in_ready = !out_vld_reg || out_ready;
    assign fire     = in_ready && in_valid;

    // Sum, arithmetic shift (rounds toward minus infinity), saturate
    always_comb begin
        acc_c = $signed({{(ACC_W-P_W){in_prod.p_term[P_W-1]}}, in_prod.p_term})
              + $signed({{(ACC_W-I_W){in_prod.i_term[I_W-1]}}, in_prod.i_term})
              + $signed({{(ACC_W-D_W){in_prod.d_term[D_W-1]}}, in_prod.d_term});
        shifted_c = acc_c[ACC_W-1:FRAC_W];
        if (shifted_c[SHIFT_W-1:DRIVE_W-1] == '0 ||
            shifted_c[SHIFT_W-1:DRIVE_W-1] == '1) begin
            drive_next = shifted_c[DRIVE_W-1:0];
        end else if (shifted_c[SHIFT_W-1]) begin
            drive_next = DRIVE_MIN;
        end else begin
            drive_next = DRIVE_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (in_ready) begin
            out_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            drive_reg <= drive_next;
            err_reg   <= in_prod.err;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_drive = drive_reg;
    assign out_err   = err_reg;

    // Shift and saturation keep the sign of the raw sum
    a_drive_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (drive_reg[DRIVE_W-1] == $past(acc_c[ACC_W-1])))
        else $error("drive sign differs from sum sign");

    // A non-negative shifted sum inside 32-bit range passes through unsaturated
    a_sat_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (shifted_c[SHIFT_W-1:DRIVE_W-1] == '0)) |=>
        (drive_reg == $past(shifted_c[DRIVE_W-1:0])))
        else $error("in-range drive was altered");

endmodule

`default_nettype wire

>>> rtl/core/positional_pid_with_integral_clamp_top.sv
// Top level of the positional PID controller with integral clamp:
// configuration registers, stream ports and the three datapath stages.
// Depends on ppid_pkg, ppid_front, ppid_mult, ppid_out.
//
// Usage:
//   Each transaction on the s_ channel carries one signed measured sample.
//   Each produces one transaction on the m_ channel with the saturated
//   drive and the error of that sample (setpoint - measured).
//   Registers are written through cfg_we/cfg_index/cfg_wdata: 0 setpoint,
//   1..3 gains P/I/D (signed Q8.8), 4 upper and 5 lower integral limit.
//   Writes to other indexes are dropped. Write only while the block is idle.
//   A result passes through the input register, error/integral stage,
//   product stage and output register.
//   Throughput: one transaction per cycle unless the receiver stalls; the
//   integral/previous-error update is combinational; samples go back to back.
//   Reset (aresetn low, synchronous) empties all stages, clears the
//   integral and previous error and loads the register defaults.
//   When the receiver stalls, each stage holds and fills in turn; s_tready
//   falls only once every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none

module positional_pid_with_integral_clamp_top import ppid_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_wdata,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // [15:0] measured
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata    // [31:0] drive, [48:32] error_now, rest 0
);

    cfg_t                       cfg_reg;
    logic                       front_valid;
    logic                       front_ready;
    front_t                     front_res;
    logic                       mult_valid;
    logic                       mult_ready;
    prod_t                      mult_prod;
    logic signed [DRIVE_W-1:0]  drive;
    logic signed [ERR_W-1:0]    error_now;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint  <= SETPOINT_RST;
            cfg_reg.gain_p    <= GAIN_P_RST;
            cfg_reg.gain_i    <= GAIN_I_RST;
            cfg_reg.gain_d    <= GAIN_D_RST;
            cfg_reg.int_upper <= INT_UP_RST;
            cfg_reg.int_lower <= INT_LO_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SETPOINT: cfg_reg.setpoint  <= cfg_wdata[SAMPLE_W-1:0];
                REG_GAIN_P:   cfg_reg.gain_p    <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:   cfg_reg.gain_i    <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:   cfg_reg.gain_d    <= cfg_wdata[GAIN_W-1:0];
                REG_INT_UP:   cfg_reg.int_upper <= cfg_wdata[INTEG_W-1:0];
                REG_INT_LO:   cfg_reg.int_lower <= cfg_wdata[INTEG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ppid_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_meas   (s_tdata[SAMPLE_W-1:0]),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_res   (front_res)
    );

    ppid_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_res    (front_res),
        .out_valid (mult_valid),
        .out_ready (mult_ready),
        .out_prod  (mult_prod)
    );

    ppid_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mult_valid),
        .in_ready  (mult_ready),
        .in_prod   (mult_prod),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_drive (drive),
        .out_err   (error_now)
    );

    assign m_tdata = {{(M_DATA_W-DRIVE_W-ERR_W){1'b0}}, error_now, drive};

endmodule

`default_nettype wire
